>>> rtl/led_blink_pattern_player_macros.svh
// Assertion macros for the LED blink pattern player.
// Included by the top level; needs nothing else.
`ifndef LED_BLINK_PATTERN_PLAYER_MACROS_SVH
`define LED_BLINK_PATTERN_PLAYER_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define BLP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define BLP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/blp_pkg.sv
// Shared types and constants of the LED blink pattern player.
// No dependencies; every other file but the macros header imports it.
package blp_pkg;

   // Default step store depth
   localparam int BLP_MAX_STEPS = 16;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIT_LEVEL_ADDR = 2'd0;
   localparam logic LIT_LEVEL_RESET = 1'b1;

   // Item operation codes
   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_WRITE_STEP = 2'd1,
      OP_SET_REPEAT = 2'd2,
      OP_SIGNAL     = 2'd3
   } blp_op_type;

   typedef struct packed {
      blp_op_type         op;
      logic               pattern_select;
      logic [3:0]         step_index;
      logic signed [15:0] step_delay;
      logic [4:0]         pattern_length;
   } blp_item_type;

   // Engine state after an item, before the pin polarity is applied
   typedef struct packed {
      logic       lit;
      logic       sig_on;
      logic [3:0] next_step;
   } blp_result_type;

   // Registered engine status
   typedef struct packed {
      logic running;
      logic lit;
      logic sig_on;
   } blp_status_type;

endpackage

>>> rtl/blp_channels.sv
// Valid/ready channel interfaces for items and results.
// Depends on blp_pkg.
interface blp_req_if import blp_pkg::*; ();
   logic               valid;
   logic               ready;
   blp_op_type         op;
   logic               pattern_select;
   logic [3:0]         step_index;
   logic signed [15:0] step_delay;
   logic [4:0]         pattern_length;

   modport source (output valid, op, pattern_select, step_index, step_delay,
                   pattern_length, input ready);
   modport sink   (input valid, op, pattern_select, step_index, step_delay,
                   pattern_length, output ready);
endinterface

interface blp_rsp_if import blp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       led_pin;
   logic       signal_playing;
   logic [3:0] next_step;

   modport source (output valid, led_pin, signal_playing, next_step, input ready);
   modport sink   (input valid, led_pin, signal_playing, next_step, output ready);
endinterface

>>> rtl/blp_csr.sv
// APB-style configuration register block: holds the pin level that lights the LED.
// Depends on blp_pkg.
module blp_csr import blp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic                  lit_level
);

   logic lit_level_ff;
   logic lit_level_in;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr == CSR_LIT_LEVEL_ADDR);
   assign lit_level_in = wr_en ? csr_pwdata[0] : lit_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_level_ff <= LIT_LEVEL_RESET;
      end else begin
         lit_level_ff <= lit_level_in;
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_LIT_LEVEL_ADDR) begin
         csr_prdata = CSR_DATA_W'(lit_level_ff);
      end
   end

   assign lit_level = lit_level_ff;

endmodule

>>> rtl/blp_engine.sv
// Sequencer state, step stores and the state update for each item.
// Depends on blp_pkg.
module blp_engine import blp_pkg::*; #(
   parameter int MAX_STEPS = BLP_MAX_STEPS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  blp_item_type   item,
   output blp_result_type result,
   output blp_status_type status
);

   localparam int PW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CW = $clog2(MAX_STEPS + 1);

   // Step stores, no reset
   logic [15:0] rep_store_ff [MAX_STEPS];
   logic [15:0] sig_store_ff [MAX_STEPS];

   logic [CW-1:0] rep_count_ff, rep_count_in;
   logic [CW-1:0] sig_count_ff, sig_count_in;
   logic          sig_on_ff, sig_on_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [14:0]   remaining_ff, remaining_in;
   logic          running_ff, running_in;
   logic          lit_ff, lit_in;

   logic [CW-1:0] len_c;
   logic          do_load;
   logic          sig_on_mid;
   logic [PW-1:0] pos_mid;
   logic [14:0]   remaining_dec;

   logic [CW-1:0] ld_count;
   logic [PW-1:0] ld_idx;
   logic [15:0]   raw;
   logic [15:0]   neg_raw;
   logic [14:0]   mag_sat;
   logic [14:0]   ld_mag;
   logic [CW-1:0] ld_next_wide;
   logic [PW-1:0] ld_next;
   logic          wr_ok;

   // Length saturates at the store depth
   assign len_c = (32'(item.pattern_length) > MAX_STEPS) ? CW'(MAX_STEPS)
                                                          : CW'(item.pattern_length);

   // Operation decode
   always_comb begin
      rep_count_in  = rep_count_ff;
      sig_count_in  = sig_count_ff;
      sig_on_mid    = sig_on_ff;
      pos_mid       = pos_ff;
      do_load       = 1'b0;
      remaining_dec = remaining_ff;
      unique case (item.op)
         OP_TICK: begin
            if (running_ff) begin
               if (remaining_ff > 15'd1) begin
                  remaining_dec = remaining_ff - 15'd1;
               end else begin
                  do_load = 1'b1;
               end
            end
         end
         OP_WRITE_STEP: begin
         end
         OP_SET_REPEAT: begin
            rep_count_in = len_c;
            if (!sig_on_ff) begin
               pos_mid = '0;
               do_load = 1'b1;
            end
         end
         OP_SIGNAL: begin
            // a cancel with no signal running is dropped
            if (sig_on_ff || (len_c != '0)) begin
               sig_count_in = len_c;
               sig_on_mid   = (len_c != '0);
               pos_mid      = '0;
               do_load      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Step load: fetch, magnitude, next position
   assign ld_count = sig_on_mid ? sig_count_in : rep_count_in;
   assign ld_idx   = (CW'(pos_mid) < ld_count) ? pos_mid : '0;
   assign raw      = sig_on_mid ? sig_store_ff[ld_idx] : rep_store_ff[ld_idx];
   assign neg_raw  = ~raw + 16'd1;
   assign mag_sat  = raw[15] ? ((raw == 16'h8000) ? 15'h7FFF : neg_raw[14:0])
                             : raw[14:0];
   assign ld_mag   = (mag_sat == 15'd0) ? 15'd1 : mag_sat;
   assign ld_next_wide = CW'(ld_idx) + CW'(1);
   assign ld_next  = (ld_next_wide >= ld_count) ? '0 : PW'(ld_next_wide);

   // Next state
   always_comb begin
      running_in   = running_ff;
      lit_in       = lit_ff;
      remaining_in = remaining_dec;
      pos_in       = pos_mid;
      sig_on_in    = sig_on_mid;
      if (do_load) begin
         if (ld_count == '0) begin
            running_in   = 1'b0;
            lit_in       = 1'b0;
            remaining_in = remaining_ff;
         end else begin
            running_in   = 1'b1;
            lit_in       = !raw[15] && (raw != 16'd0);
            remaining_in = ld_mag;
            pos_in       = ld_next;
            sig_on_in    = sig_on_mid && (ld_next != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rep_count_ff <= '0;
         sig_count_ff <= '0;
         sig_on_ff    <= 1'b0;
         pos_ff       <= '0;
         remaining_ff <= '0;
         running_ff   <= 1'b0;
         lit_ff       <= 1'b0;
      end else if (fire) begin
         rep_count_ff <= rep_count_in;
         sig_count_ff <= sig_count_in;
         sig_on_ff    <= sig_on_in;
         pos_ff       <= pos_in;
         remaining_ff <= remaining_in;
         running_ff   <= running_in;
         lit_ff       <= lit_in;
      end
   end

   // Store writes; slots past the depth are dropped
   assign wr_ok = fire && (item.op == OP_WRITE_STEP) && (32'(item.step_index) < MAX_STEPS);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         if (item.pattern_select) begin
            sig_store_ff[PW'(item.step_index)] <= item.step_delay;
         end else begin
            rep_store_ff[PW'(item.step_index)] <= item.step_delay;
         end
      end
   end

   assign result.lit       = lit_in;
   assign result.sig_on    = sig_on_in;
   assign result.next_step = 4'(pos_in);

   assign status.running = running_ff;
   assign status.lit     = lit_ff;
   assign status.sig_on  = sig_on_ff;

endmodule

>>> rtl/led_blink_pattern_player.sv
// LED blink pattern player, top level.
// Items pass an input register, then a result register; the input register moves on
// only when the result register is empty or being taken.
// Throughput: one item per cycle while the result side is ready.
// Reset clears the sequencer state, the channel stages and sets the lit level to 1;
// step stores are not cleared, and there is no clearing pass.
`include "led_blink_pattern_player_macros.svh"
module led_blink_pattern_player import blp_pkg::*; #(
   parameter int MAX_STEPS = BLP_MAX_STEPS
) (
   input  logic                  clock,
   input  logic                  reset,
   blp_req_if.sink               req_if,
   blp_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic           lit_level;
   logic           in_valid_ff, in_valid_in;
   blp_item_type   in_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           led_pin_ff;
   logic           signal_playing_ff;
   logic [3:0]     next_step_ff;
   logic           advance;
   logic           req_fire;
   blp_result_type eng_result;
   blp_status_type eng_status;

   blp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .lit_level   (lit_level)
   );

   // Handshake: input stage moves on when the result register is empty or being taken
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_fire      = req_if.valid && req_if.ready;
   assign in_valid_in   = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input item register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.op             <= req_if.op;
         in_item_ff.pattern_select <= req_if.pattern_select;
         in_item_ff.step_index     <= req_if.step_index;
         in_item_ff.step_delay     <= req_if.step_delay;
         in_item_ff.pattern_length <= req_if.pattern_length;
      end
   end

   blp_engine #(
      .MAX_STEPS (MAX_STEPS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .result (eng_result),
      .status (eng_status)
   );

   // Result register, pin polarity applied here
   always_ff @(posedge clock) begin
      if (advance) begin
         led_pin_ff        <= eng_result.lit ? lit_level : !lit_level;
         signal_playing_ff <= eng_result.sig_on;
         next_step_ff      <= eng_result.next_step;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.led_pin        = led_pin_ff;
   assign rsp_if.signal_playing = signal_playing_ff;
   assign rsp_if.next_step      = next_step_ff;

   // Checks
   `BLP_ASSERT(a_advance_fills, clock, reset, advance |=> rsp_valid_ff, "item lost")
   `BLP_ASSERT(a_dark_stopped, clock, reset, !eng_status.running |-> !eng_status.lit, "lit stopped")
   `BLP_ASSERT(a_flag_tracks, clock, reset, advance |=> (signal_playing_ff == eng_status.sig_on), "flag")
   `BLP_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (!rsp_valid_ff && !in_valid_ff), "not empty")

endmodule

>>> tb/led_blink_pattern_player_checker.sv
// Scoreboard for the LED blink pattern player: watches the item, result and CSR ports,
// predicts the pin, signal flag and next step of every item, and compares in order.
// Depends on blp_pkg and the blp_req_if / blp_rsp_if interfaces.
`timescale 1ns / 100ps

module led_blink_pattern_player_checker import blp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   blp_req_if                    req_if,
   blp_rsp_if                    rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    pending
);

   localparam int STEPS = BLP_MAX_STEPS;

   typedef struct packed {
      logic       led_pin;
      logic       signal_playing;
      logic [3:0] next_step;
   } pin_view_type;

   // Predicted sequencer state
   logic [15:0] repeat_steps [STEPS];
   logic [15:0] signal_steps [STEPS];
   logic [4:0]  repeat_len;
   logic [4:0]  signal_len;
   logic        signal_active;
   logic [3:0]  step_pos;
   logic [14:0] ms_left;
   logic        playing;
   logic        led_lit;
   logic        pin_level;

   pin_view_type pin_queue [$];
   int           miss_count = 0;
   int           pend_count = 0;

   assign mismatches = miss_count;
   assign pending    = pend_count;

   // Load the step at step_pos of whichever pattern owns the sequence
   function void load_step();
      logic [4:0]  count;
      logic [4:0]  slot;
      logic [4:0]  following;
      logic [15:0] raw;
      logic [15:0] mag;
      count = signal_active ? signal_len : repeat_len;
      if (count == 5'd0) begin
         playing = 1'b0;
         led_lit = 1'b0;
         return;
      end
      slot = ({1'b0, step_pos} < count) ? {1'b0, step_pos} : 5'd0;
      raw  = signal_active ? signal_steps[slot[3:0]] : repeat_steps[slot[3:0]];
      if (raw[15]) begin
         mag = -raw;
         // -32768 has no positive twin: hold it at the longest step
         if (mag > 16'd32767)
            mag = 16'd32767;
         led_lit = 1'b0;
      end else begin
         mag = raw;
         led_lit = (raw != 16'd0);
      end
      // zero-length step lasts one ms, dark
      if (mag == 16'd0)
         mag = 16'd1;
      ms_left = mag[14:0];
      playing = 1'b1;
      following = slot + 5'd1;
      if (following >= count)
         following = 5'd0;
      step_pos = following[3:0];
      // signal hands back once its last step is loaded
      if (signal_active && step_pos == 4'd0)
         signal_active = 1'b0;
   endfunction

   function void apply_item(input blp_op_type op, input logic sel, input logic [3:0] slot,
                            input logic [15:0] delay, input logic [4:0] len);
      logic [4:0] steps;
      steps = (len > 5'(STEPS)) ? 5'(STEPS) : len;
      case (op)
         OP_TICK: begin
            if (playing) begin
               if (ms_left > 15'd1)
                  ms_left = ms_left - 15'd1;
               else
                  load_step();
            end
         end
         OP_WRITE_STEP: begin
            if (sel)
               signal_steps[slot] = delay;
            else
               repeat_steps[slot] = delay;
         end
         OP_SET_REPEAT: begin
            repeat_len = steps;
            if (!signal_active) begin
               step_pos = 4'd0;
               load_step();
            end
         end
         default: begin
            // cancel with no signal running does nothing at all
            if (signal_active || steps != 5'd0) begin
               signal_len    = steps;
               signal_active = (steps != 5'd0);
               step_pos      = 4'd0;
               load_step();
            end
         end
      endcase
   endfunction

   task report(input string what, input pin_view_type want, input pin_view_type got);
      miss_count++;
      if (miss_count <= 10)
         $display("%0t mismatch (%s): want led %b sig %b next %0d, got led %b sig %b next %0d",
                  $realtime, what, want.led_pin, want.signal_playing, want.next_step,
                  got.led_pin, got.signal_playing, got.next_step);
   endtask

   always @(posedge clock) begin
      pin_view_type want;
      pin_view_type got;
      if (reset) begin
         repeat_len    = 5'd0;
         signal_len    = 5'd0;
         signal_active = 1'b0;
         step_pos      = 4'd0;
         ms_left       = 15'd0;
         playing       = 1'b0;
         led_lit       = 1'b0;
         pin_level     = LIT_LEVEL_RESET;
         pin_queue.delete();
      end else begin
         // register write; the user must make it only while the block is idle, which the block does not enforce
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_LIT_LEVEL_ADDR)
            pin_level = csr_pwdata[0];

         // accepted item: predict its result
         if (req_if.valid && req_if.ready) begin
            apply_item(req_if.op, req_if.pattern_select, req_if.step_index,
                       req_if.step_delay, req_if.pattern_length);
            want.led_pin        = led_lit ? pin_level : ~pin_level;
            want.signal_playing = signal_active;
            want.next_step      = step_pos;
            pin_queue.push_back(want);
         end

         // accepted result: compare with the oldest prediction
         if (rsp_if.valid && rsp_if.ready) begin
            got.led_pin        = rsp_if.led_pin;
            got.signal_playing = rsp_if.signal_playing;
            got.next_step      = rsp_if.next_step;
            if (pin_queue.size() == 0) begin
               report("result with nothing expected", '0, got);
            end else begin
               want = pin_queue.pop_front();
               if (got.led_pin !== want.led_pin)
                  report("led_pin", want, got);
               else if (got.signal_playing !== want.signal_playing)
                  report("signal_playing", want, got);
               else if (got.next_step !== want.next_step)
                  report("next_step", want, got);
            end
         end
      end
      pend_count = pin_queue.size();
   end

endmodule

>>> tb/led_blink_pattern_player_tb.sv
// Top of the LED blink pattern player testbench: clock, reset, CSR writes, item stimulus
// and result back-pressure; the checker module does all prediction and comparison.
// Depends on blp_pkg, blp_channels, the DUT and led_blink_pattern_player_checker.
`timescale 1ns / 100ps

module led_blink_pattern_player_tb import blp_pkg::*; ();

   localparam int LIMIT       = 200000;
   localparam int PHASE_ITEMS = 150;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          mismatches;
   int          pending;
   int          cycles = 0;
   int          items_sent;
   bit          calm;
   logic [15:0] repeat_written;
   logic [15:0] signal_written;

   blp_req_if req_bus ();
   blp_rsp_if rsp_bus ();

   led_blink_pattern_player u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   led_blink_pattern_player_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("FAIL led_blink_pattern_player");
         $finish;
      end
   end

   // result back-pressure: ~10% stalls, none while calm
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
   end

   // number of slots written contiguously from slot 0
   function automatic int written_prefix(input logic [15:0] mask);
      int n;
      n = 0;
      while (n < 16 && mask[n])
         n++;
      return n;
   endfunction

   // pattern length that never reaches an unwritten slot
   function automatic logic [4:0] pick_length(input logic [15:0] mask);
      int top;
      top = written_prefix(mask);
      if (top == 16 && $urandom_range(0, 7) == 0)
         return 5'($urandom_range(17, 31));
      return 5'($urandom_range(0, top));
   endfunction

   // mostly short steps, a few raw values and extremes
   function automatic logic [15:0] pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return 16'($urandom_range(0, 12) - 6);
      if (r < 93)
         return 16'($urandom);
      case ($urandom_range(0, 5))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h8001;
         3:       return 16'h0000;
         4:       return 16'h0001;
         default: return 16'hFFFF;
      endcase
   endfunction

   // one item; called and returns at a falling edge, valid left high
   task automatic send_item(input blp_op_type op, input logic sel, input logic [3:0] slot,
                            input logic [15:0] delay, input logic [4:0] len);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.op             <= op;
      req_bus.pattern_select <= sel;
      req_bus.step_index     <= slot;
      req_bus.step_delay     <= delay;
      req_bus.pattern_length <= len;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (op == OP_WRITE_STEP) begin
         if (sel)
            signal_written[slot] = 1'b1;
         else
            repeat_written[slot] = 1'b1;
      end
      items_sent++;
   endtask

   task automatic play_tick();
      send_item(OP_TICK, 1'($urandom), 4'($urandom), 16'($urandom), 5'($urandom));
   endtask

   task automatic play_write(input logic sel, input logic [3:0] slot, input logic [15:0] delay);
      send_item(OP_WRITE_STEP, sel, slot, delay, 5'($urandom));
   endtask

   task automatic play_repeat(input logic [4:0] len);
      send_item(OP_SET_REPEAT, 1'($urandom), 4'($urandom), 16'($urandom), len);
   endtask

   task automatic play_signal(input logic [4:0] len);
      send_item(OP_SIGNAL, 1'($urandom), 4'($urandom), 16'($urandom), len);
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   // APB write: setup, access, then release at the next falling edge
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      int         phase;
      int         pick;
      int         phase_end;
      logic       sel;
      logic [3:0] slot;
      logic [4:0] len;
      blp_op_type op;

      reset                  = 1'b1;
      calm                   = 1'b0;
      items_sent             = 0;
      repeat_written         = '0;
      signal_written         = '0;
      req_bus.valid          = 1'b0;
      req_bus.op             = OP_TICK;
      req_bus.pattern_select = 1'b0;
      req_bus.step_index     = '0;
      req_bus.step_delay     = '0;
      req_bus.pattern_length = '0;
      csr_psel               = 1'b0;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b0;
      csr_paddr              = '0;
      csr_pwdata             = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_write(CSR_LIT_LEVEL_ADDR, 32'd1);

      // directed: step extremes, zero step, idle tick and idle cancel
      play_write(1'b0, 4'd0, 16'h0001);
      play_write(1'b0, 4'd1, 16'h0000);
      play_write(1'b0, 4'd2, 16'h8000);
      play_write(1'b0, 4'd3, 16'hFFFF);
      play_write(1'b1, 4'd0, 16'hFFFF);
      play_write(1'b1, 4'd1, 16'h0002);
      play_write(1'b1, 4'd2, 16'h7FFF);
      play_tick();
      play_signal(5'd0);
      // repeat pattern walks through the zero step into the longest dark step
      play_repeat(5'd4);
      play_tick();
      play_tick();
      // signal plays out and hands back to the repeat pattern
      play_signal(5'd3);
      play_tick();
      play_tick();
      play_tick();
      play_repeat(5'd3);
      // repeat change under a signal waits; cancel hands back at once
      play_signal(5'd2);
      play_repeat(5'd4);
      play_signal(5'd0);
      // no pattern: stop, ticks ignored; one-step signal over an empty repeat
      play_repeat(5'd0);
      play_tick();
      play_signal(5'd1);
      play_tick();

      // random phases, each under its own pin polarity
      for (phase = 0; phase < 4; phase++) begin
         drain();
         csr_write(CSR_LIT_LEVEL_ADDR, (phase % 2 == 0) ? 32'd0 : 32'd1);
         calm = (phase == 2);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               repeat ($urandom_range(1, 20)) play_tick();
            end else if (pick < 65) begin
               sel = 1'($urandom);
               if ($urandom_range(0, 1) == 0)
                  slot = 4'(written_prefix(sel ? signal_written : repeat_written));
               else
                  slot = 4'($urandom);
               play_write(sel, slot, pick_delay());
            end else if (pick < 78) begin
               play_repeat(pick_length(repeat_written));
            end else if (pick < 90) begin
               play_signal(pick_length(signal_written));
            end else begin
               // noise: any op with random fields, lengths kept to written slots
               op = blp_op_type'($urandom_range(0, 3));
               if (op == OP_SET_REPEAT)
                  len = pick_length(repeat_written);
               else if (op == OP_SIGNAL)
                  len = pick_length(signal_written);
               else
                  len = 5'($urandom);
               send_item(op, 1'($urandom), 4'($urandom), 16'($urandom), len);
            end
         end
      end
      calm = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("PASS led_blink_pattern_player");
      else
         $display("FAIL led_blink_pattern_player");
      $finish;
   end

endmodule
